// File: hw/rtl/csfa_pkg.sv
// shared types and constants for the circular next-free slot allocator
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package csfa_pkg;

   localparam int SLOT_W            = 11;
   localparam int STATUS_W          = 2;
   localparam int ROW_BITS          = 32;
   localparam int ROW_LSB_W         = $clog2(ROW_BITS);
   localparam int MAX_SLOTS_DEFAULT = 1024;

   localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef enum logic {
      PH_UPPER,
      PH_WRAP
   } phase_type;

   // bit window applied to one row of occupancy marks
   typedef struct packed {
      logic                 lo_on;
      logic [ROW_LSB_W-1:0] lo_bit;
      logic                 hi_on;
      logic                 hi_excl;
      logic [ROW_LSB_W-1:0] hi_bit;
   } scan_ctl_type;

endpackage

// File: hw/rtl/csfa_row_mem.sv
// occupancy mark memory, one row of csfa_pkg::ROW_BITS marks per word
// one write port, one registered read port; depends on csfa_pkg
`timescale 1ns / 1ps

module csfa_row_mem #(
   parameter int ROWS = 32,
   parameter int RW   = 5
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [RW-1:0]                 wr_addr,
   input  logic [csfa_pkg::ROW_BITS-1:0] wr_data,
   input  logic [RW-1:0]                 rd_addr,
   output logic [csfa_pkg::ROW_BITS-1:0] rd_data
);

   logic [csfa_pkg::ROW_BITS-1:0] row_mem_ff [ROWS];
   logic [csfa_pkg::ROW_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= row_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/csfa_scan_unit.sv
// shared row scanner: masks one row to a bit window and finds the lowest free mark
// depends on csfa_pkg
`timescale 1ns / 1ps

module csfa_scan_unit (
   input  logic [csfa_pkg::ROW_BITS-1:0]  row_data,
   input  csfa_pkg::scan_ctl_type         ctl,
   output logic                           hit,
   output logic [csfa_pkg::ROW_LSB_W-1:0] hit_bit
);

   logic [csfa_pkg::ROW_BITS-1:0] avail;

   always_comb begin
      logic [csfa_pkg::ROW_LSB_W-1:0] pos;
      logic                           lo_ok;
      logic                           hi_ok;
      for (int b = 0; b < csfa_pkg::ROW_BITS; b++) begin
         pos   = csfa_pkg::ROW_LSB_W'(b);
         lo_ok = !ctl.lo_on || (pos >= ctl.lo_bit);
         hi_ok = !ctl.hi_on || (ctl.hi_excl ? (pos < ctl.hi_bit) : (pos <= ctl.hi_bit));
         avail[b] = !row_data[b] && lo_ok && hi_ok;
      end
   end

   // lowest set bit wins
   always_comb begin
      hit_bit = '0;
      for (int b = csfa_pkg::ROW_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_bit = csfa_pkg::ROW_LSB_W'(b);
         end
      end
   end

   assign hit = |avail;

endmodule

// File: hw/rtl/circular_next_free_slot_allocator_unit.sv
// top level of the circular next-free slot allocator: sequencer, config, result beat
// depends on csfa_pkg, csfa_row_mem, csfa_scan_unit
`timescale 1ns / 1ps

// Command-style slot allocator. A beat is taken when start is high and busy is low;
// every beat gives exactly one result beat on rsp_valid, one cycle wide, which the
// receiver cannot stall. Occupancy marks live in a memory of 32-bit rows, and one
// shared scanner masks and searches one row per cycle. Per beat: a slot out of range
// answers the cycle after acceptance with busy staying low; a release reads the row
// and then writes it back; an allocate reads rows one after another until a free
// mark is found or the search has wrapped around, visiting from 1 up to
// ceil(MAX_SLOTS/32) + 1 rows when it wraps (33 at the default size). After reset the
// block clears every row of the mark memory, one row a cycle, with busy high; csr
// writes are taken throughout.
// csr_wdata sets slot_count; a count above MAX_SLOTS acts as MAX_SLOTS.
module circular_next_free_slot_allocator_unit #(
   parameter int MAX_SLOTS = csfa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [csfa_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_valid,
   output logic [csfa_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic [csfa_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_we,
   input  logic [csfa_pkg::SLOT_W-1:0]   csr_wdata
);

   localparam int ROWS  = (MAX_SLOTS + csfa_pkg::ROW_BITS - 1) / csfa_pkg::ROW_BITS;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int G_W   = RW + csfa_pkg::ROW_LSB_W;
   localparam int GP_W  = G_W + 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > csfa_pkg::SLOT_W) ? CNT_W : csfa_pkg::SLOT_W;
   localparam int LSB_W = csfa_pkg::ROW_LSB_W;

   // config
   logic [csfa_pkg::SLOT_W-1:0] slot_count_ff;

   // sequencer state
   csfa_pkg::state_type state_ff, state_in;
   csfa_pkg::phase_type phase_ff, phase_in;
   logic [RW-1:0]       row_ff, row_in;

   // per-beat context
   csfa_pkg::op_type    op_ff;
   logic [RW-1:0]       start_row_ff;
   logic [LSB_W-1:0]    start_bit_ff;
   logic [RW-1:0]       last_row_ff;
   logic [LSB_W-1:0]    last_bit_ff;

   // result beat
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [csfa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   csfa_pkg::status_type          rsp_status_ff, rsp_status_in;

   // memory and scanner hookup
   logic                          wr_en;
   logic [RW-1:0]                 wr_addr;
   logic [csfa_pkg::ROW_BITS-1:0] wr_data;
   logic [csfa_pkg::ROW_BITS-1:0] rd_data;
   csfa_pkg::scan_ctl_type        scan_ctl;
   logic                          scan_hit;
   logic [LSB_W-1:0]              scan_bit;

   // request decode
   logic             accept;
   logic [CMP_W-1:0] count_eff;
   logic [CMP_W-1:0] slot_ext;
   logic             in_range;
   logic [G_W-1:0]   start_idx;
   logic [G_W-1:0]   last_idx;
   logic [csfa_pkg::ROW_BITS-1:0] bit_mask;

   assign accept   = start && (state_ff == csfa_pkg::ST_IDLE);
   assign busy     = (state_ff != csfa_pkg::ST_IDLE);

   // clamp count to the built size
   always_comb begin
      if (CMP_W'(slot_count_ff) > CMP_W'(MAX_SLOTS)) begin
         count_eff = CMP_W'(MAX_SLOTS);
      end else begin
         count_eff = CMP_W'(slot_count_ff);
      end
   end

   assign slot_ext  = CMP_W'(req_slot);
   assign in_range  = (slot_ext != '0) && (slot_ext <= count_eff);
   // zero-based start and last indexes, only meaningful when in range
   assign start_idx = G_W'(slot_ext - CMP_W'(1));
   assign last_idx  = G_W'(count_eff - CMP_W'(1));

   // scan window for the row under test
   always_comb begin
      scan_ctl = '0;
      if (phase_ff == csfa_pkg::PH_UPPER) begin
         // from the preferred slot up to the last counted slot
         scan_ctl.lo_on   = (row_ff == start_row_ff);
         scan_ctl.lo_bit  = start_bit_ff;
         scan_ctl.hi_on   = (row_ff == last_row_ff);
         scan_ctl.hi_excl = 1'b0;
         scan_ctl.hi_bit  = last_bit_ff;
      end else begin
         // wrap pass: from slot 1 up to just below the preferred slot
         scan_ctl.hi_on   = (row_ff == start_row_ff);
         scan_ctl.hi_excl = 1'b1;
         scan_ctl.hi_bit  = start_bit_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csfa_pkg::ST_CLEAR: begin
            if (row_ff == RW'(ROWS - 1)) begin
               state_in = csfa_pkg::ST_IDLE;
            end
         end
         csfa_pkg::ST_IDLE: begin
            if (accept && in_range) begin
               state_in = csfa_pkg::ST_SCAN;
            end
         end
         csfa_pkg::ST_SCAN: begin
            if (op_ff == csfa_pkg::OP_RELEASE || scan_hit) begin
               state_in = csfa_pkg::ST_IDLE;
            end else if (phase_ff == csfa_pkg::PH_WRAP && row_ff == start_row_ff) begin
               state_in = csfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign bit_mask = csfa_pkg::ROW_BITS'(1) << ((op_ff == csfa_pkg::OP_RELEASE) ?
                                                start_bit_ff : scan_bit);

   // datapath and outputs
   always_comb begin
      row_in        = row_ff;
      phase_in      = phase_ff;
      wr_en         = 1'b0;
      wr_addr       = row_ff;
      wr_data       = '0;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = '0;
      rsp_status_in = csfa_pkg::STATUS_OK;
      unique case (state_ff)
         csfa_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            row_in = row_ff + RW'(1);
         end
         csfa_pkg::ST_IDLE: begin
            // the first row read goes out at the accepting edge
            row_in   = start_idx[G_W-1:LSB_W];
            phase_in = csfa_pkg::PH_UPPER;
            if (accept && !in_range) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = csfa_pkg::STATUS_RANGE;
            end
         end
         csfa_pkg::ST_SCAN: begin
            if (op_ff == csfa_pkg::OP_RELEASE) begin
               wr_en        = 1'b1;
               wr_data      = rd_data & ~bit_mask;
               rsp_valid_in = 1'b1;
            end else if (scan_hit) begin
               wr_en        = 1'b1;
               wr_data      = rd_data | bit_mask;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = csfa_pkg::SLOT_W'(GP_W'({row_ff, scan_bit}) + GP_W'(1));
            end else if (phase_ff == csfa_pkg::PH_UPPER) begin
               if (row_ff == last_row_ff) begin
                  phase_in = csfa_pkg::PH_WRAP;
                  row_in   = '0;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else if (row_ff == start_row_ff) begin
               // wrap pass exhausted: every counted slot is taken
               rsp_valid_in  = 1'b1;
               rsp_status_in = csfa_pkg::STATUS_FULL;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csfa_pkg::ST_CLEAR;
         row_ff        <= '0;
         phase_ff      <= csfa_pkg::PH_UPPER;
         rsp_valid_ff  <= 1'b0;
         slot_count_ff <= csfa_pkg::SLOT_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            slot_count_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         op_ff        <= csfa_pkg::op_type'(req_operation);
         start_row_ff <= start_idx[G_W-1:LSB_W];
         start_bit_ff <= start_idx[LSB_W-1:0];
         last_row_ff  <= last_idx[G_W-1:LSB_W];
         last_bit_ff  <= last_idx[LSB_W-1:0];
      end
   end

   csfa_row_mem #(
      .ROWS (ROWS),
      .RW   (RW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (row_in),
      .rd_data (rd_data)
   );

   csfa_scan_unit u_scan (
      .row_data (rd_data),
      .ctl      (scan_ctl),
      .hit      (scan_hit),
      .hit_bit  (scan_bit)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
